// ===== sv/sha_pkg.sv =====
// Shared types and constants for the SHA-256 byte stream hasher.
// Round constants, initial hash values, controller states and command structs.
// No dependencies.
package sha_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_WORDS  = 8;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BSEL_INPUT,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic       shift_byte;
        t_byte_sel  byte_sel;
        logic       count_len;
        logic       load_work;
        logic       round_en;
        logic [5:0] round;
        logic       add_chain;
        logic       restart;
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_status;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word r;
        unique case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/sha_if.sv =====
// Stream interfaces for the SHA-256 hasher: byte input and digest word output.
// Valid/ready handshake; no dependencies.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
    modport source (output valid, data_byte, has_byte, is_last, input ready);
    modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha_ctrl.sv =====
// Controller for the SHA-256 hasher: accepts bytes, sequences padding,
// compression rounds and digest output. Depends on sha_pkg.
module sha_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_has_byte,
    input  logic                  i_is_last,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_out_idx,
    input  sha_pkg::t_dp_status   i_status,
    output sha_pkg::t_dp_cmd      o_cmd
);
    import sha_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_pad, n_pad;     // padding sequence in progress
    logic       r_first, n_first; // next pad byte is 0x80
    logic       r_len, n_len;     // writing the length field

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            r_pad   <= 1'b0;
            r_first <= 1'b0;
            r_len   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_pad   <= n_pad;
            r_first <= n_first;
            r_len   <= n_len;
        end
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_idx   = r_idx;
        n_pad   = r_pad;
        n_first = r_first;
        n_len   = r_len;
        o_cmd   = '0;
        o_cmd.byte_sel = BSEL_INPUT;
        o_cmd.round    = r_round;
        o_cmd.out_idx  = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_has_byte) begin
                        o_cmd.shift_byte = 1'b1;
                        o_cmd.count_len  = 1'b1;
                    end
                    if (i_is_last) begin
                        n_pad   = 1'b1;
                        n_first = 1'b1;
                        n_state = ST_PAD;
                    end
                    // a full block compresses before any padding
                    if (i_has_byte && i_status.fill == 6'd63) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.shift_byte = 1'b1;
                if (r_first) begin
                    o_cmd.byte_sel = BSEL_PAD;
                    n_first = 1'b0;
                end else if (r_len || i_status.fill == LEN_POS) begin
                    o_cmd.byte_sel = BSEL_LEN;
                    n_len = 1'b1;
                end else begin
                    o_cmd.byte_sel = BSEL_ZERO;
                end
                if (i_status.fill == 6'd63) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.add_chain = 1'b1;
                priority if (r_len) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(NUM_WORDS - 1)) begin
                        o_cmd.restart = 1'b1;
                        n_pad   = 1'b0;
                        n_len   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_idx = r_idx;

endmodule

// ===== sv/sha_dp.sv =====
// Datapath for the SHA-256 hasher: 512-bit block/schedule window, length
// counter, working variables and chaining words. Depends on sha_pkg.
module sha_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_dp_cmd    i_cmd,
    input  logic [7:0]          i_data_byte,
    output sha_pkg::t_dp_status o_status,
    output logic [31:0]         o_word
);
    import sha_pkg::*;

    logic [511:0] r_win;      // block bytes, later the message schedule window
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    t_word        r_chain [NUM_WORDS];
    t_word        r_work  [NUM_WORDS];

    logic [7:0] s_byte;
    logic [5:0] s_len_sh;
    t_word w0, w1, w9, w14, s0, s1, w_new;
    t_word big0, big1, ch, maj, t1, t2;

    function automatic t_word ror(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // length bytes go out most significant first, one per fill position 56..63
    assign s_len_sh = LEN_POS - {r_fill[2:0], 3'b000};

    always_comb begin
        unique case (i_cmd.byte_sel)
            BSEL_INPUT: s_byte = i_data_byte;
            BSEL_PAD:   s_byte = PAD_BYTE;
            BSEL_ZERO:  s_byte = 8'h00;
            default:    s_byte = 8'(r_bits >> s_len_sh);
        endcase
    end

    // schedule: word 0 is w[t], so words 1, 9 and 14 are w[t+1], w[t+9], w[t+14], the terms for w[t+16]
    assign w0    = r_win[511:480];
    assign w1    = r_win[479:448];
    assign w9    = r_win[223:192];
    assign w14   = r_win[63:32];
    assign s0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
    assign s1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + s0 + w9 + s1;

    assign big1 = ror(r_work[4], 6) ^ ror(r_work[4], 11) ^ ror(r_work[4], 25);
    assign ch   = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign t1   = r_work[7] + big1 + ch + round_k(i_cmd.round) + w0;
    assign big0 = ror(r_work[0], 2) ^ ror(r_work[0], 13) ^ ror(r_work[0], 22);
    assign maj  = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
    assign t2   = big0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            r_win <= {r_win[503:0], s_byte};
        end else if (i_cmd.round_en) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.shift_byte) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.restart) begin
                r_bits <= '0;
            end else if (i_cmd.count_len) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) r_chain[i] <= iv_word(3'(i));
        end else if (i_cmd.restart) begin
            for (int i = 0; i < NUM_WORDS; i++) r_chain[i] <= iv_word(3'(i));
        end else if (i_cmd.add_chain) begin
            for (int i = 0; i < NUM_WORDS; i++) r_chain[i] <= r_chain[i] + r_work[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < NUM_WORDS; i++) r_work[i] <= r_chain[i];
        end else if (i_cmd.round_en) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + t2;
        end
    end

    assign o_status.fill = r_fill;
    assign o_word        = r_chain[i_cmd.out_idx];

endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher top level: joins the controller and datapath
// to the input and output stream interfaces. Depends on sha_pkg, sha_if.
//
// Usage:
//   Input channel i_in carries one item per transaction: data_byte, has_byte
//   and is_last. An item with has_byte appends data_byte to the message; an
//   item with is_last pads and finishes the message. An item with neither
//   changes nothing.
//   Output channel o_out carries the eight digest words, word_index 0 first,
//   last_word set on word 7. After word 7 is taken the hasher restarts from
//   the initial hash values.
//   Flow: a byte that does not complete a 64-byte block leaves the hasher
//   ready for the next item. A byte that completes a block starts the
//   compression (load, 64 rounds of the single round unit, chaining add). A
//   last item writes padding bytes up to the block end, runs one or two
//   compressions, then offers the digest words. Input ready is low throughout.
//   A stalled receiver holds the current digest word; nothing is dropped.
//   Reset is synchronous: chaining words return to the initial hash values,
//   fill count and bit length clear, and the output channel goes idle.
module sha256_byte_stream_hasher (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sha_in_if.sink   i_in,
    sha_out_if.source o_out
);
    import sha_pkg::*;

    t_dp_cmd    s_cmd;
    t_dp_status s_status;
    logic [2:0] s_idx;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_has_byte  (i_in.has_byte),
        .i_is_last   (i_in.is_last),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_idx   (s_idx),
        .i_status    (s_status),
        .o_cmd       (s_cmd)
    );

    sha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .i_data_byte (i_in.data_byte),
        .o_status    (s_status),
        .o_word      (o_out.digest_word)
    );

    assign o_out.word_index = s_idx;
    assign o_out.last_word  = (s_idx == 3'(NUM_WORDS - 1));

endmodule

// ===== sv/sha_chk.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on the top level's port signals only.
module sha_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_word_index,
    input logic        i_last_word
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while digest pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == 3'd7)))
        else $error("last_word mismatch");

    a_idx_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_word) |=>
        (i_out_valid && i_word_index == $past(i_word_index) + 3'd1))
        else $error("digest word order broken");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (i_word_index == 3'd0))
        else $error("digest does not start at word 0");
endmodule

bind sha256_byte_stream_hasher sha_chk u_sha_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_word_index (o_out.word_index),
    .i_last_word  (o_out.last_word)
);

// ===== tb/tb.sv =====
// Testbench for sha256_byte_stream_hasher: drives byte items, predicts digests
// with an independent SHA-256 model and checks every digest word in order.
// Depends on sha_pkg, sha_if and the hasher RTL.
`timescale 1ns / 1ps

module tb;
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_item;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_byte_stream_hasher DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    localparam int IDLE_LIMIT = 20000;

    // SHA-256 constants, kept locally so prediction stays independent of the RTL
    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] bit_length;

    t_digest_item digest_queue [$];
    int  error_count;
    int  idle_cycles;
    bit  timed_out;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                    hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TABLE[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
        block_fill = 0;
        bit_length = '0;
    endtask

    // Update the model with one accepted item and queue any digest words
    task automatic predict_digest(logic [7:0] data, logic has_byte, logic is_last);
        int pos;
        t_digest_item item;
        if (has_byte) begin
            msg_block[block_fill] = data;
            block_fill++;
            bit_length += 64'd8;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (!is_last) return;
        pos = block_fill;
        msg_block[pos++] = PAD_BYTE;
        if (pos > 56) begin
            while (pos < 64) msg_block[pos++] = 8'h00;
            compress_block();
            pos = 0;
        end
        while (pos < 56) msg_block[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[56+i] = bit_length[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            item.digest_word = hash_state[i];
            item.word_index  = 3'(i);
            item.last_word   = (i == 7);
            digest_queue = {digest_queue, item};
        end
        restart_hash();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    bit gaps_on;

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(logic [7:0] data, logic has_byte, logic is_last);
        int gap;
        gap = gaps_on ? random_gap() : 0;
        if (gap > 0) begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= data;
        in_ch.has_byte  <= has_byte;
        in_ch.is_last   <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_digest(data, has_byte, is_last);
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, bit fold_last);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, fold_last && (i == len - 1));
        if (!fold_last || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Drop valid, then hold until every expected digest word has arrived
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (digest_queue.size() != 0 && !timed_out) @(negedge i_clk);
    endtask

    // Output side: random stall, sample at the rising edge
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= (random_gap() == 0);
        end
    end

    always @(posedge i_clk) begin
        t_digest_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_queue.size() == 0) begin
                report_mismatch("unexpected digest word", out_ch.digest_word, '0);
            end else begin
                want = digest_queue.pop_front();
                if (out_ch.digest_word !== want.digest_word)
                    report_mismatch("digest_word", out_ch.digest_word, want.digest_word);
                if (out_ch.word_index !== want.word_index)
                    report_mismatch("word_index", 32'(out_ch.word_index), 32'(want.word_index));
                if (out_ch.last_word !== want.last_word)
                    report_mismatch("last_word", 32'(out_ch.last_word), 32'(want.last_word));
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("sha256_byte_stream_hasher test failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);                 // empty message
        send_item(8'h00, 1'b0, 1'b0);                 // no-op item
        send_item(8'hff, 1'b1, 1'b1);                 // byte and last together
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);                 // ignored byte
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_message(55, 1'b1);                       // padding just fits
        send_message(56, 1'b0);                       // padding needs an extra block
        send_message(64, 1'b1);                       // exactly one full block
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < 150) begin
            case ($urandom_range(0, 5))
                0:       len = $urandom_range(0, 3);
                1:       len = $urandom_range(54, 66);
                2:       len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 40);
            endcase
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_message(len, $urandom_range(0, 1));
            sent += len + 1;
        end
    endtask

    task automatic test_pause_until_drained();
        send_message(20, 1'b0);
        wait_drained();
        send_message(3, 1'b1);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        for (int m = 0; m < 4; m++) send_message($urandom_range(0, 70), 1'b1);
        gaps_on = 1'b1;
    endtask

    initial begin
        error_count     = 0;
        idle_cycles     = 0;
        timed_out       = 1'b0;
        gaps_on         = 1'b1;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.has_byte  = 1'b0;
        in_ch.is_last   = 1'b0;
        i_rst_n         = 1'b0;
        restart_hash();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_pause_until_drained();
        test_random_messages();
        test_back_to_back();

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("sha256_byte_stream_hasher test passed");
        else
            $display("sha256_byte_stream_hasher test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_ctrl.sv
sv/sha_dp.sv
sv/sha256_byte_stream_hasher.sv
sv/sha_chk.sv
tb/tb.sv
